>>> design/lav_pkg.sv
package lav_pkg;

  // Fraction bits of the fixed-point format
  localparam int FRAC_BITS_DEF = 16;

  // Accumulator width: three exact 64-bit products plus sign
  localparam int ACC_W = 66;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;

  // Input stream width: nine 32-bit coordinates
  localparam int IN_W = 288;
  // Output stream width: value and index, padded to whole bytes
  localparam int OUT_W = 40;

  // Operand program of the shared multiply-accumulate unit
  typedef enum logic [1:0] {
    MS_SQ,
    MS_CROSS,
    MS_UP,
    MS_DOT
  } msel_t;

  // One multiply-accumulate term: operand indexes, subtract, accumulator
  typedef struct packed {
    logic [1:0] ia;
    logic [1:0] ib;
    logic       sub;
    logic [1:0] dst;
  } term_t;

  // Item handed from the front end to the back end
  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] up;
    logic [2:0][32:0] d;
  } lav_item_t;

  // Number of terms for each program
  function automatic logic [3:0] term_count(input msel_t sel);
    logic [3:0] n;
    case (sel)
      MS_SQ:    n = 4'd3;
      MS_CROSS: n = 4'd6;
      MS_UP:    n = 4'd6;
      default:  n = 4'd9;
    endcase
    return n;
  endfunction

  // Term table: cross products a x b, dot products and sum of squares
  function automatic term_t term_of(input msel_t sel, input logic [3:0] k);
    term_t t;
    t = '0;
    case (sel)
      MS_CROSS, MS_UP: begin
        case (k)
          4'd0:    t = '{ia: 2'd1, ib: 2'd2, sub: 1'b0, dst: 2'd0};
          4'd1:    t = '{ia: 2'd2, ib: 2'd1, sub: 1'b1, dst: 2'd0};
          4'd2:    t = '{ia: 2'd2, ib: 2'd0, sub: 1'b0, dst: 2'd1};
          4'd3:    t = '{ia: 2'd0, ib: 2'd2, sub: 1'b1, dst: 2'd1};
          4'd4:    t = '{ia: 2'd0, ib: 2'd1, sub: 1'b0, dst: 2'd2};
          default: t = '{ia: 2'd1, ib: 2'd0, sub: 1'b1, dst: 2'd2};
        endcase
      end
      MS_SQ: begin
        t.ia = k[1:0];
        t.ib = k[1:0];
      end
      default: begin
        if (k < 4'd3) begin
          t.ia  = k[1:0];
          t.dst = 2'd0;
        end else if (k < 4'd6) begin
          t.ia  = 2'(k - 4'd3);
          t.dst = 2'd1;
        end else begin
          t.ia  = 2'(k - 4'd6);
          t.dst = 2'd2;
        end
        t.ib = t.ia;
      end
    endcase
    return t;
  endfunction

endpackage

>>> design/look_at_view_matrix.sv
// Look-at view matrix generator in signed fixed point (FRAC_BITS fraction
// bits). One input transaction carries eye, target and up vectors; the block
// emits the 16 matrix elements in storage order, one per output transaction,
// with tlast on element 15 and tuser set on all 16 when the forward or side
// vector had zero length. A two-entry input queue takes new transactions
// while the back end works. The computation uses a normalizing shifter and a
// bit-serial square root, run once per unit vector, and a bit-serial divider,
// run once per vector component, and is followed by the output of the 16
// elements; the next matrix starts once the last element enters the output
// register.
module look_at_view_matrix #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
  input  logic [lav_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // element_value [31:0], element_index [35:32], zero pad [39:36]
  output logic [lav_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                      m_axis_tlast,
  // degenerate
  output logic                      m_axis_tuser
);

  logic               q_valid;
  logic               q_pop;
  lav_pkg::lav_item_t q_item;

  lav_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_tdata  (s_axis_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  lav_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tlast  (m_axis_tlast),
    .m_tuser  (m_axis_tuser)
  );

endmodule

>>> design/lav_front.sv
module lav_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [lav_pkg::IN_W-1:0] s_tdata,
  output logic                   q_valid,
  output lav_pkg::lav_item_t     q_item,
  input  logic                   q_pop
);

  lav_pkg::lav_item_t ent [2];
  lav_pkg::lav_item_t wr_item;
  logic               wptr;
  logic               rptr;
  logic [1:0]         cnt;
  logic               push;

  assign s_tready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = ent[rptr];
  assign push     = s_tvalid && s_tready;

  // Unpack coordinates and form target minus eye
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wr_item.eye[i] = s_tdata[32*i +: 32];
      wr_item.up[i]  = s_tdata[32*(6+i) +: 32];
      wr_item.d[i]   = 33'($signed({s_tdata[32*(3+i)+31], s_tdata[32*(3+i) +: 32]})
                     - $signed({s_tdata[32*i+31], s_tdata[32*i +: 32]}));
    end
  end

  // Store the transaction in the queue
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= wr_item;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> design/lav_back.sv
module lav_back #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  lav_pkg::lav_item_t        q_item,
  output logic                      q_pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [lav_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tlast,
  output logic                      m_tuser
);

  localparam int AW = lav_pkg::ACC_W;
  localparam int NW = 31 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam logic signed [AW:0] HALF = (AW+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [AW:0] RMAX = (AW+1)'(64'sd2147483647);
  localparam logic signed [AW:0] RMIN = -(AW+1)'(64'sd2147483648);
  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_ABS, S_NORM, S_MAC, S_SQRT, S_DIVLD, S_DIV, S_UDONE, S_RNDU, S_RNDT, S_EMIT
  } state_t;

  state_t                 state;
  lav_pkg::msel_t         msel;
  logic                   job_side;
  logic                   deg;
  logic [3:0]             term;
  logic signed [AW-1:0]   acc [3];
  logic [AW-1:0]          a [3];
  logic                   vneg [3];
  logic signed [31:0]     eye [3];
  logic signed [31:0]     upv [3];
  logic signed [31:0]     fv [3];
  logic signed [31:0]     sv [3];
  logic signed [31:0]     uv [3];
  logic signed [31:0]     tv [3];
  logic signed [31:0]     rv [3];
  logic signed [65:0]     prod;
  logic                   p_vld;
  logic                   p_sub;
  logic [1:0]             p_dst;
  logic [63:0]            sx;
  logic [63:0]            sres;
  logic [63:0]            sbit;
  logic [4:0]             scnt;
  logic [NW-1:0]          num;
  logic [32:0]            rem;
  logic [CW-1:0]          dcnt;
  logic [1:0]             comp;
  logic [31:0]            nreg;
  logic [3:0]             idx;
  logic signed [31:0]     oval;
  logic [3:0]             oidx;

  // Combinational helpers
  lav_pkg::term_t         tm;
  logic [3:0]             mac_cnt;
  logic signed [32:0]     opa;
  logic signed [32:0]     opb;
  logic [AW-1:0]          orv;
  logic                   big;
  logic                   small_m;
  logic [63:0]            s_try;
  logic                   s_ge;
  logic [32:0]            d_try;
  logic                   d_ge;
  logic [NW-1:0]          quot;
  logic [31:0]            q32;
  logic signed [31:0]     el_val;
  logic                   slot_free;

  // Round half up to the fraction bits, optionally negate, saturate
  function automatic logic signed [31:0] rnd_sat(input logic signed [AW-1:0] x,
                                                 input logic neg);
    logic signed [AW:0] r;
    r = $signed({x[AW-1], x}) + HALF;
    r = r >>> FRAC_BITS;
    if (neg) begin
      r = -r;
    end
    if (r > RMAX) begin
      return lav_pkg::Q_MAX;
    end else if (r < RMIN) begin
      return ~lav_pkg::Q_MAX;
    end
    return r[31:0];
  endfunction

  // Select the operands of the current term
  always_comb begin
    tm      = lav_pkg::term_of(msel, term);
    mac_cnt = lav_pkg::term_count(msel);
    opa     = '0;
    opb     = '0;
    case (msel)
      lav_pkg::MS_SQ: begin
        opa = $signed({3'b000, a[tm.ia][29:0]});
        opb = opa;
      end
      lav_pkg::MS_CROSS: begin
        opa = 33'(fv[tm.ia]);
        opb = 33'(upv[tm.ib]);
      end
      lav_pkg::MS_UP: begin
        opa = 33'(sv[tm.ia]);
        opb = 33'(fv[tm.ib]);
      end
      default: begin
        case (tm.dst)
          2'd0:    opa = 33'(sv[tm.ia]);
          2'd1:    opa = 33'(uv[tm.ia]);
          default: opa = 33'(fv[tm.ia]);
        endcase
        opb = 33'(eye[tm.ib]);
      end
    endcase
  end

  // Normalize window, square-root step, divider step
  always_comb begin
    orv     = a[0] | a[1] | a[2];
    big     = |orv[AW-1:30];
    small_m = ~|orv[AW-1:29];
    s_try   = sres + sbit;
    s_ge    = (sx >= s_try);
    d_try   = {rem[31:0], num[NW-1]};
    d_ge    = (d_try >= {1'b0, nreg});
    quot    = {num[NW-2:0], d_ge};
    q32     = (|quot[NW-1:31]) ? 32'(lav_pkg::Q_MAX) : {1'b0, quot[30:0]};
  end

  // Pick the element at the current storage position
  always_comb begin
    el_val = '0;
    if (idx[3:2] == 2'd3) begin
      case (idx[1:0])
        2'd3:    el_val = ONE;
        default: el_val = tv[idx[1:0]];
      endcase
    end else begin
      case (idx[1:0])
        2'd0:    el_val = sv[idx[3:2]];
        2'd1:    el_val = uv[idx[3:2]];
        2'd2:    el_val = -fv[idx[3:2]];
        default: el_val = '0;
      endcase
    end
  end

  assign slot_free = !m_tvalid || m_tready;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign m_tdata   = {4'b0000, oidx, oval};
  assign m_tlast   = (oidx == 4'hF);

  // Multiplier stage
  always_ff @(posedge clk) begin
    prod  <= opa * opb;
    p_sub <= tm.sub;
    p_dst <= tm.dst;
  end

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      p_vld    <= 1'b0;
      term     <= '0;
      idx      <= '0;
      job_side <= 1'b0;
      msel     <= lav_pkg::MS_SQ;
    end else begin
      p_vld <= (state == S_MAC) && (term < mac_cnt);
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      // accumulate the product of the previous cycle
      if (p_vld) begin
        acc[p_dst] <= acc[p_dst] + (p_sub ? -AW'(prod) : AW'(prod));
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            for (int i = 0; i < 3; i++) begin
              eye[i] <= $signed(q_item.eye[i]);
              upv[i] <= $signed(q_item.up[i]);
              acc[i] <= AW'($signed(q_item.d[i]));
            end
            deg      <= 1'b0;
            job_side <= 1'b0;
            state    <= S_ABS;
          end
        end
        S_ABS: begin
          for (int i = 0; i < 3; i++) begin
            a[i]    <= acc[i][AW-1] ? AW'(-acc[i]) : AW'(acc[i]);
            vneg[i] <= acc[i][AW-1];
          end
          if (acc[0] == '0 && acc[1] == '0 && acc[2] == '0) begin
            for (int i = 0; i < 3; i++) begin
              rv[i] <= lav_pkg::Q_MAX;
            end
            deg   <= 1'b1;
            state <= S_UDONE;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (big) begin
            for (int i = 0; i < 3; i++) a[i] <= a[i] >> 1;
          end else if (small_m) begin
            for (int i = 0; i < 3; i++) a[i] <= a[i] << 1;
          end else begin
            for (int i = 0; i < 3; i++) acc[i] <= '0;
            msel  <= lav_pkg::MS_SQ;
            term  <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (term < mac_cnt) begin
            term  <= term + 4'd1;
          end else begin
            term <= '0;
            case (msel)
              lav_pkg::MS_SQ: begin
                // fold in the last square, still in the multiplier register
                sx    <= acc[0][63:0] + prod[63:0];
                sres  <= '0;
                sbit  <= 64'h4000_0000_0000_0000;
                scnt  <= '0;
                state <= S_SQRT;
              end
              lav_pkg::MS_CROSS: begin
                job_side <= 1'b1;
                state    <= S_ABS;
              end
              lav_pkg::MS_UP: state <= S_RNDU;
              default:        state <= S_RNDT;
            endcase
          end
        end
        S_SQRT: begin
          if (s_ge) begin
            sx   <= sx - s_try;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          scnt <= scnt + 5'd1;
          if (scnt == 5'd31) begin
            nreg  <= s_ge ? 32'((sres >> 1) + sbit) : 32'(sres >> 1);
            comp  <= 2'd0;
            state <= S_DIVLD;
          end
        end
        S_DIVLD: begin
          num   <= (NW'(a[comp][29:0]) << FRAC_BITS) + NW'(nreg >> 1);
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= d_ge ? (d_try - {1'b0, nreg}) : d_try;
          num  <= quot;
          dcnt <= dcnt + CW'(1);
          if (dcnt == CW'(NW - 1)) begin
            rv[comp] <= vneg[comp] ? -$signed(q32) : $signed(q32);
            if (comp == 2'd2) begin
              state <= S_UDONE;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_DIVLD;
            end
          end
        end
        S_UDONE: begin
          for (int i = 0; i < 3; i++) begin
            acc[i] <= '0;
            if (job_side) sv[i] <= rv[i];
            else          fv[i] <= rv[i];
          end
          msel  <= job_side ? lav_pkg::MS_UP : lav_pkg::MS_CROSS;
          term  <= '0;
          state <= S_MAC;
        end
        S_RNDU: begin
          for (int i = 0; i < 3; i++) begin
            uv[i]  <= rnd_sat(acc[i], 1'b0);
            acc[i] <= '0;
          end
          msel  <= lav_pkg::MS_DOT;
          term  <= '0;
          state <= S_MAC;
        end
        S_RNDT: begin
          tv[0] <= rnd_sat(acc[0], 1'b1);
          tv[1] <= rnd_sat(acc[1], 1'b1);
          tv[2] <= rnd_sat(acc[2], 1'b0);
          idx   <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            m_tvalid <= 1'b1;
            oval     <= el_val;
            oidx     <= idx;
            m_tuser  <= deg;
            idx      <= idx + 4'd1;
            if (idx == 4'hF) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/lav_check.sv
module lav_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [lav_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast,
  input logic                      m_axis_tuser
);

  // No output transaction right after reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // tlast marks exactly the last storage position
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[35:32] == 4'hF)))
    else $error("tlast does not match element index");

  // Pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[39:36] == 4'h0))
    else $error("nonzero pad bits");

  // Stalled output transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output changed");

  // Accepted non-last element is followed by the next index
  a_next_idx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
      m_axis_tdata[35:32] == 4'($past(m_axis_tdata[35:32]) + 4'd1))
    else $error("element index skipped");

endmodule

bind look_at_view_matrix lav_check u_lav_check (.*);

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int      FB        = lav_pkg::FRAC_BITS_DEF;
  localparam longint  SAT_HI    = 64'sd2147483647;
  localparam longint  SAT_LO    = -64'sd2147483648;
  localparam int      N_RANDOM  = 380;
  localparam int      HOLD_LEN  = 3000;
  localparam int      DRAIN_CYC = 600;
  localparam longint  CYC_LIMIT = 3000000;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;
  localparam logic [31:0] MAX_Q = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_Q = 32'h8000_0000;

  typedef longint vec3_t [3];

  // One matrix element as seen on the output stream
  typedef struct {
    logic [31:0] value;
    logic [3:0]  index;
    logic        last;
    logic        deg;
  } elem_t;

  // Directed row: nine coordinates, eye_x lowest; degenerate flag typed in where obvious
  typedef struct {
    logic [8:0][31:0] coords;
    bit               deg_known;
    bit               deg_val;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [lav_pkg::IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [lav_pkg::OUT_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;

  elem_t  matrix_q[$];
  row_t   dir_tab[$];
  int     err_cnt = 0;
  int     sent_cnt = 0;
  bit     quiet = 1'b0;
  bit     hold_req = 1'b0;
  longint cyc = 0;

  look_at_view_matrix dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYC_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint clamp32(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w >>= 2;
    while (bit_w != 0) begin
      if (x >= res + bit_w) begin
        x -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // Exact sum of products, rounded half up to FB fraction bits
  function automatic longint round_fix(input longint p0, input longint p1, input longint p2);
    longint hi;
    longint unsigned lo;
    hi = (p0 >>> FB) + (p1 >>> FB) + (p2 >>> FB);
    lo = longint'(p0[FB-1:0]) + longint'(p1[FB-1:0]) + longint'(p2[FB-1:0]);
    lo += 64'd1 << (FB - 1);
    return hi + longint'(lo >> FB);
  endfunction

  // Normalize to unit length; a zero vector saturates every component
  function automatic void normalize(input vec3_t v, output vec3_t o, inout bit deg);
    longint unsigned a[3];
    longint unsigned mx, sum, n, q;
    for (int i = 0; i < 3; i++) a[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
    mx = a[0];
    if (a[1] > mx) mx = a[1];
    if (a[2] > mx) mx = a[2];
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = SAT_HI;
      deg = 1'b1;
      return;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) a[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) a[i] <<= 1;
    end
    sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    n = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << FB) + n / 2) / n;
      if (q > SAT_HI) q = SAT_HI;
      o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  // Build the view matrix and queue its 16 elements
  task automatic predict_matrix(input logic [8:0][31:0] c, input bit deg_known,
                                input bit deg_val);
    vec3_t eye, up, d, f, sr, s, u;
    longint m [16];
    bit deg;
    elem_t e;
    deg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(c[i]));
      up[i]  = longint'($signed(c[6+i]));
      d[i]   = longint'($signed(c[3+i])) - eye[i];
    end
    normalize(d, f, deg);
    sr[0] = f[1] * up[2] - f[2] * up[1];
    sr[1] = f[2] * up[0] - f[0] * up[2];
    sr[2] = f[0] * up[1] - f[1] * up[0];
    normalize(sr, s, deg);
    u[0] = clamp32(round_fix(s[1] * f[2], -(s[2] * f[1]), 0));
    u[1] = clamp32(round_fix(s[2] * f[0], -(s[0] * f[2]), 0));
    u[2] = clamp32(round_fix(s[0] * f[1], -(s[1] * f[0]), 0));
    for (int i = 0; i < 3; i++) begin
      m[4*i]   = s[i];
      m[4*i+1] = u[i];
      m[4*i+2] = clamp32(-f[i]);
      m[4*i+3] = 0;
    end
    m[12] = clamp32(-round_fix(s[0] * eye[0], s[1] * eye[1], s[2] * eye[2]));
    m[13] = clamp32(-round_fix(u[0] * eye[0], u[1] * eye[1], u[2] * eye[2]));
    m[14] = clamp32(round_fix(f[0] * eye[0], f[1] * eye[1], f[2] * eye[2]));
    m[15] = longint'(ONE_Q);
    if (deg_known) deg = deg_val;
    for (int i = 0; i < 16; i++) begin
      e.value = m[i][31:0];
      e.index = 4'(i);
      e.last  = (i == 15);
      e.deg   = deg;
      matrix_q.push_back(e);
    end
  endtask

  // Offer one transaction and hold it until accepted
  task automatic send_item(input logic [8:0][31:0] c, input bit deg_known, input bit deg_val);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk); while (!s_axis_tready);
    predict_matrix(c, deg_known, deg_val);
    sent_cnt++;
    // Insert a random gap after the transaction
    if (!quiet && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic row_t mk(input logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz,
                              input bit dk, input bit dv);
    row_t r;
    r.coords = {uz, uy, ux, tz, ty, tx, ez, ey, ex};
    r.deg_known = dk;
    r.deg_val = dv;
    return r;
  endfunction

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? ($urandom & 32'h000F_FFFF) : -($urandom & 32'h000F_FFFF);
      2: return $urandom_range(1) ? ($urandom & 32'h00FF_FFFF) : -($urandom & 32'h00FF_FFFF);
      default: return $urandom_range(1) ? MAX_Q - $urandom_range(255) : MIN_Q + $urandom_range(255);
    endcase
  endfunction

  // Check accepted elements and pace the output side
  initial begin
    elem_t exp_e;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        if (matrix_q.size() == 0) begin
          $display("%0t: unexpected element value=%h index=%0d", $realtime,
                   m_axis_tdata[31:0], m_axis_tdata[35:32]);
          err_cnt++;
        end else begin
          exp_e = matrix_q.pop_front();
          if (m_axis_tdata[31:0] !== exp_e.value) begin
            $display("%0t: element %0d value expected %h actual %h", $realtime,
                     exp_e.index, exp_e.value, m_axis_tdata[31:0]);
            err_cnt++;
          end
          if (m_axis_tdata[35:32] !== exp_e.index) begin
            $display("%0t: index expected %0d actual %0d", $realtime,
                     exp_e.index, m_axis_tdata[35:32]);
            err_cnt++;
          end
          if (m_axis_tlast !== exp_e.last) begin
            $display("%0t: element %0d last expected %b actual %b", $realtime,
                     exp_e.index, exp_e.last, m_axis_tlast);
            err_cnt++;
          end
          if (m_axis_tuser !== exp_e.deg) begin
            $display("%0t: element %0d degenerate expected %b actual %b", $realtime,
                     exp_e.index, exp_e.deg, m_axis_tuser);
            err_cnt++;
          end
        end
      end
      // Hold off the output for a long stretch once
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      m_axis_tready <= rst ? 1'b0 : (quiet || $urandom_range(99) >= 18);
    end
  end

  initial begin
    row_t r;
    logic [31:0] ex, ey, ez, tx, ty, tz;
    int kind;
    // Directed rows: degenerate cases, a plain camera and field extremes
    dir_tab.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    dir_tab.push_back(mk(ONE_Q, 2*ONE_Q, 3*ONE_Q, ONE_Q, 2*ONE_Q, 3*ONE_Q, 0, ONE_Q, 0, 1, 1));
    dir_tab.push_back(mk(0, 0, 0, 0, ONE_Q, 0, 0, ONE_Q, 0, 1, 1));
    dir_tab.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    dir_tab.push_back(mk(0, 0, 5*ONE_Q, 0, 0, 0, 0, ONE_Q, 0, 1, 0));
    dir_tab.push_back(mk(0, 0, 0, ONE_Q, 0, 0, 0, 0, ONE_Q, 1, 0));
    dir_tab.push_back(mk(0, 0, 0, 0, 0, 1, 1, 0, 0, 1, 0));
    dir_tab.push_back(mk(MIN_Q, MIN_Q, MIN_Q, MAX_Q, MAX_Q, MAX_Q, 0, ONE_Q, 0, 1, 0));
    dir_tab.push_back(mk(MAX_Q, MAX_Q, MAX_Q, MIN_Q, MIN_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, 0, 0));
    dir_tab.push_back(mk(MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MIN_Q, MIN_Q, 0, 0));
    dir_tab.push_back(mk(MAX_Q, MIN_Q, 0, MIN_Q, MAX_Q, 0, MAX_Q, MAX_Q, MAX_Q, 0, 0));
    dir_tab.push_back(mk('1, '1, '1, 0, 0, 0, '1, 0, '1, 0, 0));
    dir_tab.push_back(mk(0, 0, 0, MAX_Q, 0, 0, MIN_Q, 0, 0, 1, 1));
    dir_tab.push_back(mk(MAX_Q, 0, 0, MIN_Q, 0, 0, 0, MIN_Q, 0, 1, 0));
    dir_tab.push_back(mk(1, 2, 3, 4, 5, 6, 7, 8, 9, 0, 0));
    dir_tab.push_back(mk(32'h0000_8000, 32'hFFFF_8000, 0, 0, 0, 32'h0000_8000, 1, 1, 1, 0, 0));
    dir_tab.push_back(mk(0, 0, 0, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 1, 1));
    dir_tab.push_back(mk(3*ONE_Q, -2*ONE_Q, 7*ONE_Q, 0, 0, 0, 0, 0, ONE_Q, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_item(dir_tab[i].coords, dir_tab[i].deg_known, dir_tab[i].deg_val);

    for (int n = 0; n < N_RANDOM; n++) begin
      // Stretch with no idling on either side
      quiet = (n >= 40 && n < 100);
      if (n == 150) hold_req = 1'b1;
      if (n == 250) begin
        s_axis_tvalid <= 1'b0;
        while (matrix_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
      end
      ex = rnd_coord(); ey = rnd_coord(); ez = rnd_coord();
      tx = rnd_coord(); ty = rnd_coord(); tz = rnd_coord();
      kind = $urandom_range(19);
      if (kind == 0) begin
        // Eye on target
        r = mk(ex, ey, ez, ex, ey, ez, rnd_coord(), rnd_coord(), rnd_coord(), 0, 0);
      end else if (kind == 1) begin
        // Up along the forward direction
        r = mk(0, 0, 0, tx, ty, tz, tx, ty, tz, 0, 0);
      end else if (kind == 2) begin
        r = mk(ex, ey, ez, tx, ty, tz, 0, 0, 0, 0, 0);
      end else begin
        r = mk(ex, ey, ez, tx, ty, tz, rnd_coord(), rnd_coord(), rnd_coord(), 0, 0);
      end
      send_item(r.coords, 0, 0);
    end
    quiet = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (matrix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
